@@ rtl/core/ptt_pkg.sv @@
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants of the proximity tap trigger table: item
// structs, register codes, reset values and controller states.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // Configuration port shape
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RSSI_THR    = 3'd0,
    CFG_SCORE_INC   = 3'd1,
    CFG_SCORE_THR   = 3'd2,
    CFG_SCORE_MAX   = 3'd3,
    CFG_TIMEOUT     = 3'd4
  } ptt_cfg_e;

  // Register reset values
  localparam logic signed [7:0] RSSI_THR_RST  = -8'sd70;
  localparam logic [7:0]        SCORE_INC_RST = 8'd100;
  localparam logic [7:0]        SCORE_THR_RST = 8'd150;
  localparam logic [7:0]        SCORE_MAX_RST = 8'd200;
  localparam logic [15:0]       TIMEOUT_RST   = 16'd20;

  // Payload constants
  localparam int unsigned TAP_FLAG_BIT = 2;
  localparam logic [7:0]  SCORE_TOP    = 8'hFF;

  // Input item
  typedef struct packed {
    logic              mode;
    logic              well_formed;
    logic signed [7:0] signal_strength;
    logic [47:0]       device_address;
    logic [7:0]        payload_flags;
  } ptt_in_t;

  // Result item
  typedef struct packed {
    logic       toggle;
    logic [1:0] entry_index;
    logic [7:0] entry_score;
  } ptt_out_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_PUSH
  } ptt_state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;   // item accepted: latch address, clear result, reset the scan
    logic tick;   // item accepted and is a tick: age the table
    logic scan;   // compare one entry
    logic apply;  // update chosen entry and build result
    logic push;   // move result to the output register
  } ptt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic in_tick;     // item at the port is a tick
    logic in_qualify;  // item at the port is a counting advertisement
    logic scan_last;   // scan is on the last entry
    logic out_free;    // output register can take a result this cycle
  } ptt_sts_t;

endpackage

@@ rtl/core/proximity_tap_trigger_table.sv @@
// ----------------------------------------------------------------------------
// proximity_tap_trigger_table
// Tracks up to TABLE_ENTRIES nearby device addresses with a leaky score each
// and raises toggle on the advertisement whose score first crosses the
// score threshold, after which a hold-off counter blocks scoring for
// timeout_ticks ticks. Each accepted item yields exactly one result item.
// A tick or an ignored advertisement has its result moved to the output
// register as soon as that register is free; a counting advertisement first
// passes the table search, which compares one entry per cycle on a single
// read port, then the entry update, then the load of the output register.
// The next item can be taken once its result sits in the output register,
// even if that result is still stalled. Configuration writes are meant for
// idle periods only; there is no clearing pass after reset.
// ----------------------------------------------------------------------------
module proximity_tap_trigger_table
  import ptt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  ptt_in_t               in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output ptt_out_t              out_item_o
);

  ptt_cmd_t cmd;
  ptt_sts_t sts;

  // Sequence the item
  ptt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  // Table, search and output register
  ptt_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  // An accepted item keeps the input stalled in the following cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input taken again right after an accept");

  // The entry update only follows a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.apply |-> $past(cmd.scan))
    else $error("entry update without a preceding scan");

  // A pushed result shows up at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |=> out_valid_o)
    else $error("pushed result not presented");

  // No push over a result that is still stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.push |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while stalled");
`endif

endmodule

@@ rtl/core/ptt_ctrl.sv @@
// ----------------------------------------------------------------------------
// ptt_ctrl
// Controller of the proximity tap trigger table: sequences accept, table
// scan, entry update and result hand-off.
// ----------------------------------------------------------------------------
module ptt_ctrl
  import ptt_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  ptt_sts_t sts_i,
  output logic     in_stall_o,
  output ptt_cmd_t cmd_o
);

  ptt_state_e state_q, state_d;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = (sts_i.in_tick || !sts_i.in_qualify) ? ST_PUSH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_last) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_d = ST_PUSH;
      end
      ST_PUSH: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        cmd_o.load = in_valid_i;
        cmd_o.tick = in_valid_i && sts_i.in_tick;
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
      end
      ST_APPLY: begin
        cmd_o.apply = 1'b1;
      end
      ST_PUSH: begin
        cmd_o.push = sts_i.out_free;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/core/ptt_datapath.sv @@
// ----------------------------------------------------------------------------
// ptt_datapath
// Datapath of the proximity tap trigger table: configuration registers,
// address and score table, one-entry-per-cycle search, score update,
// hold-off counter and output register.
// ----------------------------------------------------------------------------
module ptt_datapath
  import ptt_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  ptt_in_t               in_item_i,
  input  ptt_cmd_t              cmd_i,
  output ptt_sts_t              sts_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output ptt_out_t              out_item_o
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Configuration registers
  logic signed [7:0] rssi_thr_q;
  logic [7:0]        score_inc_q;
  logic [7:0]        score_thr_q;
  logic [7:0]        score_max_q;
  logic [15:0]       timeout_q;

  // Table
  logic [47:0] addr_q  [TABLE_ENTRIES];
  logic [7:0]  score_q [TABLE_ENTRIES];
  logic [15:0] holdoff_q;

  // Search state
  logic [47:0]      item_addr_q;
  logic [IDX_W-1:0] scan_cnt_q;
  logic             found_q;
  logic [IDX_W-1:0] best_idx_q;
  logic [7:0]       best_score_q;
  logic [7:0]       lowest_q;

  // Result and output register
  ptt_out_t result_q, result_d;
  ptt_out_t out_item_q;
  logic     out_valid_q;

  // Scan compare
  logic [47:0] cur_addr;
  logic [7:0]  cur_score;
  logic        hit;

  // Update
  logic [7:0] prev_score;
  logic [8:0] sum;
  logic [7:0] capped;
  logic [7:0] new_score;
  logic       trig;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rssi_thr_q  <= RSSI_THR_RST;
      score_inc_q <= SCORE_INC_RST;
      score_thr_q <= SCORE_THR_RST;
      score_max_q <= SCORE_MAX_RST;
      timeout_q   <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (ptt_cfg_e'(cfg_idx_i))
        CFG_RSSI_THR:  rssi_thr_q  <= $signed(cfg_wdata_i[7:0]);
        CFG_SCORE_INC: score_inc_q <= cfg_wdata_i[7:0];
        CFG_SCORE_THR: score_thr_q <= cfg_wdata_i[7:0];
        CFG_SCORE_MAX: score_max_q <= cfg_wdata_i[7:0];
        CFG_TIMEOUT:   timeout_q   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Classify the item at the port
  always_comb begin
    sts_o.in_tick    = in_item_i.mode;
    sts_o.in_qualify = in_item_i.well_formed
                       && (in_item_i.signal_strength >= rssi_thr_q)
                       && in_item_i.payload_flags[TAP_FLAG_BIT];
    sts_o.scan_last  = (scan_cnt_q == LAST_IDX);
    sts_o.out_free   = !out_valid_q || !out_stall_i;
  end

  // Read one entry per scan cycle
  always_comb begin
    cur_addr  = addr_q[scan_cnt_q];
    cur_score = score_q[scan_cnt_q];
    hit       = (cur_addr == item_addr_q);
  end

  // Latch the address and hold it for the scan
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_addr_q <= in_item_i.device_address;
    end
  end

  // Advance the scan: first match wins, else first entry with lowest score
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_cnt_q <= '0;
      found_q    <= 1'b0;
      best_idx_q <= '0;
    end else if (cmd_i.load) begin
      scan_cnt_q <= '0;
      found_q    <= 1'b0;
      best_idx_q <= '0;
    end else if (cmd_i.scan) begin
      scan_cnt_q <= scan_cnt_q + IDX_W'(1);
      if (!found_q) begin
        if (hit) begin
          found_q    <= 1'b1;
          best_idx_q <= scan_cnt_q;
        end else if (cur_score < lowest_q) begin
          best_idx_q <= scan_cnt_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      lowest_q     <= SCORE_TOP;
      best_score_q <= '0;
    end else if (cmd_i.scan && !found_q) begin
      if (hit) begin
        best_score_q <= cur_score;
      end else if (cur_score < lowest_q) begin
        lowest_q     <= cur_score;
        best_score_q <= cur_score;
      end
    end
  end

  // Compute the new score of the chosen entry; a replaced entry starts at zero
  always_comb begin
    prev_score = found_q ? best_score_q : 8'd0;
    sum        = {1'b0, prev_score} + {1'b0, score_inc_q};
    capped     = (sum > {1'b0, score_max_q}) ? score_max_q : sum[7:0];
    if (holdoff_q == 16'd0) begin
      new_score = capped;
      trig      = (prev_score <= score_thr_q) && (capped > score_thr_q);
    end else begin
      new_score = prev_score;
      trig      = 1'b0;
    end
    result_d.toggle      = trig;
    result_d.entry_index = 2'(best_idx_q);
    result_d.entry_score = new_score;
  end

  // Age or update the table
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        addr_q[i]  <= '0;
        score_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (cmd_i.tick) begin
          if (score_q[i] != 8'd0) begin
            score_q[i] <= score_q[i] - 8'd1;
          end
        end else if (cmd_i.apply && (best_idx_q == IDX_W'(i))) begin
          addr_q[i]  <= item_addr_q;
          score_q[i] <= new_score;
        end
      end
    end
  end

  // Hold-off counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holdoff_q <= '0;
    end else if (cmd_i.tick) begin
      if (holdoff_q != 16'd0) begin
        holdoff_q <= holdoff_q - 16'd1;
      end
    end else if (cmd_i.apply && trig) begin
      holdoff_q <= timeout_q;
    end
  end

  // Build the result: zero for ticks and ignored items
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      result_q <= '0;
    end else if (cmd_i.apply) begin
      result_q <= result_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_item_q <= result_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

@@ dv/proximity_tap_trigger_table_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// proximity_tap_trigger_table_tb
// Self-checking bench for the proximity tap trigger table. A shadow copy of
// the address table, leaky scores, hold-off counter and registers predicts
// the verdict of every accepted advertisement or tick. Each returned verdict
// is checked field by field against the oldest prediction. Directed items
// cover the register extremes and corner cases. Random traffic then runs
// under several idle and stall mixes and one long output hold-off.
// ----------------------------------------------------------------------------
module proximity_tap_trigger_table_tb;
  import ptt_pkg::*;

  localparam int unsigned TABLE_ENTRIES = 4;
  localparam int unsigned ADDR_POOL     = 6;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned QUIET_LIMIT   = 4000;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned ROUND_ITEMS   = 150;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd5;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  ptt_in_t               in_item_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  ptt_out_t              out_item_o;

  // Bench control
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned err_count;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          long_hold_req;

  // Verdicts still owed by the block, oldest first
  ptt_out_t pending_verdicts[$];

  // Shadow table and registers
  logic [47:0]       tbl_addr[TABLE_ENTRIES];
  logic [7:0]        tbl_score[TABLE_ENTRIES];
  logic [15:0]       holdoff_left;
  logic signed [7:0] cfg_rssi_thr;
  logic [7:0]        cfg_score_inc;
  logic [7:0]        cfg_score_thr;
  logic [7:0]        cfg_score_max;
  logic [15:0]       cfg_timeout;

  logic [47:0] addr_pool[ADDR_POOL];

  proximity_tap_trigger_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Age the shadow table on a tick, otherwise score a counting advertisement
  function automatic ptt_out_t predict_trigger(ptt_in_t it);
    ptt_out_t    res;
    int unsigned slot;
    int unsigned lowest;
    int unsigned prev;
    int unsigned total;
    bit          hit;
    bit          have_low;
    res      = '0;
    slot     = 0;
    lowest   = SCORE_TOP;
    hit      = 1'b0;
    have_low = 1'b0;
    if (it.mode) begin
      foreach (tbl_score[i]) begin
        if (tbl_score[i] != 8'd0) tbl_score[i] = tbl_score[i] - 8'd1;
      end
      if (holdoff_left != 16'd0) holdoff_left = holdoff_left - 16'd1;
      return res;
    end
    if (!it.well_formed || $signed(it.signal_strength) < cfg_rssi_thr ||
        !it.payload_flags[TAP_FLAG_BIT]) begin
      return res;
    end
    // Search for the address, tracking the first lowest score on the way
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_addr[i] == it.device_address) begin
        slot = i;
        hit  = 1'b1;
        break;
      end
      if (tbl_score[i] < lowest) begin
        lowest   = tbl_score[i];
        slot     = i;
        have_low = 1'b1;
      end
    end
    // Replace an entry for a new address; fall back to entry 0 when all are full
    if (!hit) begin
      if (!have_low) slot = 0;
      tbl_addr[slot]  = it.device_address;
      tbl_score[slot] = 8'd0;
    end
    // Score only while the hold-off has run out
    if (holdoff_left == 16'd0) begin
      prev  = tbl_score[slot];
      total = prev + cfg_score_inc;
      if (total > cfg_score_max) total = cfg_score_max;
      tbl_score[slot] = 8'(total);
      if (prev <= cfg_score_thr && total > cfg_score_thr) begin
        holdoff_left = cfg_timeout;
        res.toggle   = 1'b1;
      end
    end
    res.entry_index = 2'(slot);
    res.entry_score = tbl_score[slot];
    return res;
  endfunction

  // Mirror a register write into the shadow copy
  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_RSSI_THR:  cfg_rssi_thr  = data[7:0];
      CFG_SCORE_INC: cfg_score_inc = data[7:0];
      CFG_SCORE_THR: cfg_score_thr = data[7:0];
      CFG_SCORE_MAX: cfg_score_max = data[7:0];
      CFG_TIMEOUT:   cfg_timeout   = data;
      default: ;
    endcase
  endfunction

  function automatic ptt_in_t advert(logic [47:0] addr, logic signed [7:0] rssi,
                                     logic [7:0] flags, logic formed);
    ptt_in_t it;
    it.mode            = 1'b0;
    it.well_formed     = formed;
    it.signal_strength = rssi;
    it.device_address  = addr;
    it.payload_flags   = flags;
    return it;
  endfunction

  function automatic ptt_in_t tick_item(logic [65:0] fill);
    ptt_in_t it;
    it      = fill;
    it.mode = 1'b1;
    return it;
  endfunction

  // Mostly counting advertisements from a small address pool, plus ticks and noise
  function automatic ptt_in_t make_item();
    ptt_in_t     it;
    int unsigned pick;
    it.mode            = 1'($urandom_range(0, 1));
    it.well_formed     = 1'($urandom_range(0, 1));
    it.signal_strength = 8'($urandom());
    it.device_address  = {16'($urandom()), 32'($urandom())};
    it.payload_flags   = 8'($urandom());
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      it.mode = 1'b1;
    end else if (pick < 88) begin
      it.mode                        = 1'b0;
      it.well_formed                 = 1'b1;
      it.payload_flags[TAP_FLAG_BIT] = 1'b1;
      it.signal_strength = 8'($urandom_range(int'(cfg_rssi_thr) + 128, 255) - 128);
      it.device_address  = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
    end else begin
      it.mode = 1'b0;
      if (pick < 94) it.device_address = addr_pool[$urandom_range(0, ADDR_POOL - 1)];
    end
    return it;
  endfunction

  // Offer one item, idling first at random, and log its verdict on accept
  task automatic send_item(input ptt_in_t it);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    pending_verdicts.push_back(predict_trigger(it));
  endtask

  // Drop valid and wait until every verdict has come back
  task automatic wait_table_quiet();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    apply_register(idx, data);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Reset values: zero address matches entry 0, each reason to ignore an item
  task automatic test_reset_defaults();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(advert(48'h0, -8'sd70, 8'h04, 1'b1));
    send_item(advert(48'hFFFF_FFFF_FFFF, 8'sd127, 8'hFF, 1'b1));
    send_item(advert(48'h0, 8'sd127, 8'hFF, 1'b0));
    send_item(advert(48'h0, -8'sd71, 8'hFF, 1'b1));
    send_item(advert(48'hFFFF_FFFF_FFFF, 8'sd127, 8'hFB, 1'b1));
    send_item(advert(48'h0, -8'sd128, 8'h04, 1'b1));
    send_item(tick_item({66{1'b1}}));
    send_item(tick_item('0));
    wait_table_quiet();
  endtask

  // Register extremes: saturation, all-full fallback, lowered ceiling, hold-off
  task automatic test_register_extremes();
    write_reg(CFG_RSSI_THR, 16'h007F);
    write_reg(CFG_SCORE_INC, 16'hFFFF);
    write_reg(CFG_SCORE_THR, 16'h0000);
    write_reg(CFG_SCORE_MAX, 16'h00FF);
    write_reg(CFG_TIMEOUT, 16'h0000);
    write_reg(CFG_IDX_SPARE, 16'hFFFF);
    send_item(advert(48'h1111_2222_3333, 8'sd126, 8'h04, 1'b1));
    send_item(advert(48'h1111_2222_3333, 8'sd127, 8'h04, 1'b1));
    send_item(advert(48'h4444_5555_6666, 8'sd127, 8'h04, 1'b1));
    send_item(advert(48'h7777_8888_9999, 8'sd127, 8'h04, 1'b1));
    send_item(advert(48'hAAAA_BBBB_CCCC, 8'sd127, 8'h04, 1'b1));
    send_item(advert(48'h8000_0000_0001, 8'sd127, 8'h04, 1'b1));
    send_item(advert(48'h1111_2222_3333, 8'sd127, 8'h04, 1'b1));
    wait_table_quiet();
    // Lowered ceiling pulls a full score down; no crossing possible
    write_reg(CFG_SCORE_MAX, 16'hA532);
    write_reg(CFG_SCORE_INC, 16'h0000);
    write_reg(CFG_RSSI_THR, 16'h0080);
    write_reg(CFG_TIMEOUT, 16'hFFFF);
    write_reg(CFG_SCORE_THR, 16'h00FF);
    send_item(advert(48'h1111_2222_3333, -8'sd128, 8'h04, 1'b1));
    send_item(tick_item('0));
    wait_table_quiet();
    // Short hold-off: trigger, blocked rescore, tick, rescore
    write_reg(CFG_SCORE_THR, 16'h0010);
    write_reg(CFG_SCORE_INC, 16'h0020);
    write_reg(CFG_SCORE_MAX, 16'h00FF);
    write_reg(CFG_TIMEOUT, 16'h0001);
    send_item(advert(48'h0123_4567_89AB, 8'sd0, 8'h04, 1'b1));
    send_item(advert(48'h0123_4567_89AB, 8'sd0, 8'h04, 1'b1));
    send_item(tick_item('0));
    send_item(advert(48'h0123_4567_89AB, 8'sd0, 8'h04, 1'b1));
    wait_table_quiet();
  endtask

  task automatic write_random_config();
    write_reg(CFG_RSSI_THR, {8'($urandom()), 8'(int'($urandom_range(0, 80)) - 110)});
    write_reg(CFG_SCORE_INC, {8'($urandom()), 8'($urandom_range(1, 140))});
    write_reg(CFG_SCORE_THR, {8'($urandom()), 8'($urandom_range(0, 220))});
    if ($urandom_range(0, 99) < 80) begin
      write_reg(CFG_SCORE_MAX, {8'($urandom()), 8'($urandom_range(cfg_score_thr, 255))});
    end else begin
      write_reg(CFG_SCORE_MAX, {8'($urandom()), 8'($urandom())});
    end
    write_reg(CFG_TIMEOUT, 16'($urandom_range(0, 12)));
  endtask

  // Random traffic in rounds, each with its own settings and address pool
  task automatic test_random_traffic(input int unsigned sender_idle,
                                     input int unsigned receiver_stall);
    idle_pct  = sender_idle;
    stall_pct = receiver_stall;
    for (int r = 0; r < 3; r++) begin
      write_random_config();
      foreach (addr_pool[i]) addr_pool[i] = {16'($urandom()), 32'($urandom())};
      if ($urandom_range(0, 3) == 0) addr_pool[0] = '0;
      for (int n = 0; n < ROUND_ITEMS; n++) send_item(make_item());
      wait_table_quiet();
    end
  endtask

  // Hold the output for a long stretch while items keep coming
  task automatic test_backpressure();
    idle_pct      = 0;
    stall_pct     = 0;
    long_hold_req = 1'b1;
    for (int n = 0; n < 40; n++) send_item(make_item());
    wait_table_quiet();
  endtask

  // Receiver: random stall, or a long hold when asked
  always @(negedge clk_i) begin
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end else if (hold_left != 0) begin
      hold_left = hold_left - 1;
    end
    out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
  end

  // Check each accepted verdict against the oldest prediction
  always @(posedge clk_i) begin
    ptt_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_verdicts.size() == 0) begin
        $error("verdict with none expected: toggle %0b entry_index %0d entry_score %0d",
               out_item_o.toggle, out_item_o.entry_index, out_item_o.entry_score);
        err_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (out_item_o.toggle !== want.toggle) begin
          $error("toggle mismatch: expected %0b, got %0b", want.toggle, out_item_o.toggle);
          err_count++;
        end
        if (out_item_o.entry_index !== want.entry_index) begin
          $error("entry_index mismatch: expected %0d, got %0d",
                 want.entry_index, out_item_o.entry_index);
          err_count++;
        end
        if (out_item_o.entry_score !== want.entry_score) begin
          $error("entry_score mismatch: expected %0d, got %0d",
                 want.entry_score, out_item_o.entry_score);
          err_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    out_stall_i   = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    err_count     = 0;
    quiet_cycles  = 0;
    hold_left     = 0;
    long_hold_req = 1'b0;
    foreach (tbl_addr[i]) begin
      tbl_addr[i]  = '0;
      tbl_score[i] = '0;
    end
    foreach (addr_pool[i]) addr_pool[i] = '0;
    holdoff_left  = '0;
    cfg_rssi_thr  = RSSI_THR_RST;
    cfg_score_inc = SCORE_INC_RST;
    cfg_score_thr = SCORE_THR_RST;
    cfg_score_max = SCORE_MAX_RST;
    cfg_timeout   = TIMEOUT_RST;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_register_extremes();
    test_random_traffic(0, 0);
    test_random_traffic(75, 0);
    test_random_traffic(0, 75);
    test_random_traffic(35, 35);
    test_backpressure();
    wait_table_quiet();

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
